// ===== src/cts_pkg.sv =====
// package for the coprocessor task scheduler: codes, widths and result layout
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

   // task state codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_YIELD = 2'd1;
   localparam logic [1:0] ST_AUDIO = 2'd2;
   localparam logic [1:0] ST_GFX   = 2'd3;

   // start command codes
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_AUDIO  = 2'd1;
   localparam logic [1:0] CMD_GFX    = 2'd2;
   localparam logic [1:0] CMD_RESUME = 2'd3;

   // event kind codes
   localparam logic [2:0] EV_TASK_DONE    = 3'd0;
   localparam logic [2:0] EV_RETRACE      = 3'd1;
   localparam logic [2:0] EV_AUDIO_READY  = 3'd2;
   localparam logic [2:0] EV_GFX_READY    = 3'd3;
   localparam logic [2:0] EV_DISPLAY_DONE = 3'd4;

   localparam int INTERVAL_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // one result, lowest field last so the packed order matches tdata
   typedef struct packed {
      logic [1:0] task_state_out;
      logic       unit_busy;
      logic       display_done;
      logic       frame_tick;
      logic       audio_tick;
      logic       flush_request;
      logic       yield_request;
      logic [1:0] start_cmd;
   } result_type;

endpackage

`default_nettype wire

// ===== src/coprocessor_task_scheduler_unit.sv =====
// top level of the coprocessor task scheduler: event register, update logic, result register
//
// Usage:
//   req_ channel carries one event per transaction: req_tuser is the event kind,
//   req_tdata carries the yield and reset-pending flags. Every event yields exactly
//   one result transaction on the rsp_ channel, in order.
//   csr_wr_en / csr_wr_data write the frame interval register (8 bit, reset 1); the
//   value is loaded into the active interval at each frame tick.
// Pipeline and throughput:
//   an event is registered on acceptance and its result is registered from the event
//   register once the result register is free or being taken. One event per cycle is
//   sustained while rsp_tready stays high; the scheduler state updates in the same step
//   that writes the result register.
// Reset:
//   synchronous, active high. Task state idle, all flags clear, frame counter
//   restarted so the first retrace already gives a frame tick at interval 1.
// Stall:
//   while rsp_tready is low the result holds; one further event is held in the event
//   register, after which req_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module coprocessor_task_scheduler_unit
   import cts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // event channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [0] gfx_did_yield, [1] reset_pending
   input  wire logic [2:0]            req_tuser,   // [2:0] mode
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] start_cmd, [2] yield_request, [3] flush_request, [4] audio_tick,
   // [5] frame_tick, [6] display_done, [7] unit_busy, [9:8] task_state_out
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [INTERVAL_W-1:0] csr_wr_data
);

   // event register
   logic       ev_valid_ff;
   logic [2:0] ev_mode_ff;
   logic       ev_yield_ff;
   logic       ev_rst_ff;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   // scheduler state
   logic [1:0]            state_ff, state_in;
   logic                  busy_ff, busy_in;
   logic                  yielded_ff, yielded_in;
   logic                  queued_ff, queued_in;
   // retraces since the last frame tick, never above the interval
   logic [INTERVAL_W-1:0] since_ff, since_in;
   logic [INTERVAL_W-1:0] active_ff, active_in;
   logic [INTERVAL_W-1:0] frame_interval_ff;

   logic                  advance;
   logic [INTERVAL_W:0]   since_inc;

   assign advance    = ev_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !ev_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_ff};
   assign since_inc  = {1'b0, since_ff} + {{INTERVAL_W{1'b0}}, 1'b1};

   // event update
   always_comb begin
      state_in   = state_ff;
      yielded_in = yielded_ff;
      queued_in  = queued_ff;
      since_in   = since_ff;
      active_in  = active_ff;
      rsp_in     = '0;
      case (ev_mode_ff)
         EV_TASK_DONE: begin
            case (state_ff)
               ST_YIELD: begin
                  if (ev_yield_ff) yielded_in = 1'b1;
                  rsp_in.start_cmd = CMD_AUDIO;
                  state_in = ST_AUDIO;
               end
               ST_AUDIO: begin
                  if (yielded_ff) begin
                     yielded_in = 1'b0;
                     rsp_in.start_cmd = CMD_RESUME;
                     state_in = ST_GFX;
                  end else if (queued_ff) begin
                     queued_in = 1'b0;
                     rsp_in.start_cmd = CMD_GFX;
                     state_in = ST_GFX;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               ST_GFX:  state_in = ST_IDLE;
               default: state_in = state_ff;
            endcase
         end
         EV_RETRACE: begin
            rsp_in.audio_tick = 1'b1;
            if (since_inc >= {1'b0, active_ff}) begin
               since_in = '0;
               active_in = frame_interval_ff;
               rsp_in.frame_tick = 1'b1;
            end else begin
               since_in = since_inc[INTERVAL_W-1:0];
            end
         end
         EV_AUDIO_READY: begin
            rsp_in.flush_request = 1'b1;
            if (busy_ff) begin
               if (state_ff != ST_YIELD) begin
                  rsp_in.yield_request = 1'b1;
                  state_in = ST_YIELD;
               end
            end else begin
               rsp_in.start_cmd = CMD_AUDIO;
               state_in = ST_AUDIO;
            end
         end
         EV_GFX_READY: begin
            if (!ev_rst_ff) begin
               rsp_in.flush_request = 1'b1;
               if (busy_ff) begin
                  queued_in = 1'b1;
               end else begin
                  rsp_in.start_cmd = CMD_GFX;
                  state_in = ST_GFX;
               end
            end
         end
         EV_DISPLAY_DONE: rsp_in.display_done = 1'b1;
         default: rsp_in = '0;
      endcase
      busy_in = (state_in != ST_IDLE);
      rsp_in.unit_busy = busy_in;
      rsp_in.task_state_out = state_in;
   end

   // event register load
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else if (req_tready) begin
         ev_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         ev_mode_ff  <= req_tuser;
         ev_yield_ff <= req_tdata[0];
         ev_rst_ff   <= req_tdata[1];
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         yielded_ff   <= 1'b0;
         queued_ff    <= 1'b0;
         since_ff     <= INTERVAL_W'(1);
         active_ff    <= INTERVAL_W'(1);
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
            busy_ff      <= busy_in;
            yielded_ff   <= yielded_in;
            queued_ff    <= queued_in;
            since_ff     <= since_in;
            active_ff    <= active_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_interval_ff <= INTERVAL_W'(1);
      end else if (csr_wr_en) begin
         frame_interval_ff <= csr_wr_data;
      end
   end

   // busy flag always tracks a non-idle state
   a_busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy flag out of step with task state");

   // a yield request leaves the unit yielding
   a_yield_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.yield_request) |-> (rsp_ff.task_state_out == ST_YIELD))
      else $error("yield request without yielding state");

   // frame ticks only come with a retrace
   a_frame_on_retrace: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_tick) |-> rsp_ff.audio_tick)
      else $error("frame tick without retrace");

   // a result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");

   // any start command leaves a running task
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.start_cmd != CMD_NONE) |-> rsp_ff.unit_busy)
      else $error("start command without busy unit");

endmodule

`default_nettype wire

// ===== bench/tb_coprocessor_task_scheduler_unit.sv =====
// testbench for the coprocessor task scheduler: directed and random events against a predictor
`timescale 1ns / 1ps

module tb_coprocessor_task_scheduler_unit;
   import cts_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 7;
   localparam int LONG_HOLD = 64;
   localparam int SETTLE_CYCLES = 20;

   // event kinds the block must ignore
   localparam logic [2:0] EV_RSVD_5 = 3'd5;
   localparam logic [2:0] EV_RSVD_6 = 3'd6;
   localparam logic [2:0] EV_RSVD_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [0] gfx_did_yield, [1] reset_pending
   logic [2:0] req_tuser = '0;              // [2:0] mode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [1:0] start_cmd, [2] yield_request, [3] flush_request, [4] audio_tick,
   // [5] frame_tick, [6] display_done, [7] unit_busy, [9:8] task_state_out
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [INTERVAL_W-1:0] csr_wr_data = '0;

   // predicted scheduler state, busy is implied by a non-idle task state
   logic [1:0] sched_state = ST_IDLE;
   logic gfx_parked = 1'b0;
   logic gfx_waiting = 1'b0;
   logic [31:0] retrace_cnt = 32'd1;
   logic [31:0] last_frame_cnt = 32'd0;
   logic [INTERVAL_W-1:0] cur_interval = 8'd1;
   logic [INTERVAL_W-1:0] next_interval = 8'd1;

   result_type expected_results[$];
   int error_count = 0;
   int result_index = 0;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   bit hold_off_req = 1'b0;

   coprocessor_task_scheduler_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // next scheduler state and outputs for one event
   function automatic result_type predict_event(input logic [2:0] kind, input logic did_yield,
                                                input logic rst_pend);
      result_type r;
      r = '0;
      case (kind)
         EV_TASK_DONE: begin
            if (sched_state == ST_YIELD) begin
               if (did_yield) gfx_parked = 1'b1;
               r.start_cmd = CMD_AUDIO;
               sched_state = ST_AUDIO;
            end else if (sched_state == ST_AUDIO) begin
               if (gfx_parked) begin
                  gfx_parked = 1'b0;
                  r.start_cmd = CMD_RESUME;
                  sched_state = ST_GFX;
               end else if (gfx_waiting) begin
                  gfx_waiting = 1'b0;
                  r.start_cmd = CMD_GFX;
                  sched_state = ST_GFX;
               end else begin
                  sched_state = ST_IDLE;
               end
            end else if (sched_state == ST_GFX) begin
               sched_state = ST_IDLE;
            end
         end
         EV_RETRACE: begin
            r.audio_tick = 1'b1;
            retrace_cnt = retrace_cnt + 32'd1;
            if ((retrace_cnt - last_frame_cnt) >= {24'd0, cur_interval}) begin
               last_frame_cnt = retrace_cnt;
               cur_interval = next_interval;
               r.frame_tick = 1'b1;
            end
         end
         EV_AUDIO_READY: begin
            r.flush_request = 1'b1;
            if (sched_state != ST_IDLE) begin
               if (sched_state != ST_YIELD) begin
                  r.yield_request = 1'b1;
                  sched_state = ST_YIELD;
               end
            end else begin
               r.start_cmd = CMD_AUDIO;
               sched_state = ST_AUDIO;
            end
         end
         EV_GFX_READY: begin
            // graphics is dropped once system reset has begun
            if (!rst_pend) begin
               r.flush_request = 1'b1;
               if (sched_state != ST_IDLE) begin
                  gfx_waiting = 1'b1;
               end else begin
                  r.start_cmd = CMD_GFX;
                  sched_state = ST_GFX;
               end
            end
         end
         EV_DISPLAY_DONE: r.display_done = 1'b1;
         default: ;
      endcase
      r.unit_busy = (sched_state != ST_IDLE);
      r.task_state_out = sched_state;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH result %0d: %s", $time, result_index, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // offer one event transaction and record its expected result on acceptance
   task automatic send_event(input logic [2:0] kind, input logic did_yield,
                             input logic rst_pend);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= REQ_DATA_W'({rst_pend, did_yield});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_event(kind, did_yield, rst_pend));
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // write the frame interval while the block is idle
   task automatic write_frame_interval(input logic [INTERVAL_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      next_interval = value;
      csr_wr_en <= 1'b0;
   endtask

   // every event kind and every special scheduling transition from reset
   task automatic test_directed_events();
      send_event(EV_TASK_DONE, 1'b1, 1'b1);      // task done while idle
      send_event(EV_DISPLAY_DONE, 1'b0, 1'b0);
      send_event(EV_RSVD_5, 1'b1, 1'b1);
      send_event(EV_RSVD_6, 1'b0, 1'b1);
      send_event(EV_RSVD_7, 1'b1, 1'b0);
      send_event(EV_GFX_READY, 1'b0, 1'b1);      // ignored during reset
      send_event(EV_GFX_READY, 1'b1, 1'b0);      // start graphics
      send_event(EV_GFX_READY, 1'b0, 1'b0);      // queued while busy
      send_event(EV_AUDIO_READY, 1'b0, 1'b0);    // graphics asked to yield
      send_event(EV_AUDIO_READY, 1'b1, 1'b1);    // already yielding: flush only
      send_event(EV_TASK_DONE, 1'b1, 1'b0);      // yielded, audio starts
      send_event(EV_TASK_DONE, 1'b0, 1'b0);      // resume graphics
      send_event(EV_TASK_DONE, 1'b0, 1'b0);      // graphics done
      send_event(EV_AUDIO_READY, 1'b0, 1'b0);    // start audio from idle
      send_event(EV_AUDIO_READY, 1'b0, 1'b0);    // audio preempted by audio
      send_event(EV_TASK_DONE, 1'b0, 1'b0);      // did not yield, audio starts
      send_event(EV_TASK_DONE, 1'b0, 1'b0);      // queued graphics starts
      send_event(EV_TASK_DONE, 1'b1, 1'b1);
      send_event(EV_AUDIO_READY, 1'b0, 1'b1);
      send_event(EV_TASK_DONE, 1'b0, 1'b0);      // audio done, nothing pending
      repeat (3) send_event(EV_RETRACE, 1'b1, 1'b1);
   endtask

   // frame tick spacing at zero, small and full-scale intervals
   task automatic test_frame_interval();
      wait_results_drained();
      write_frame_interval(8'd0);
      repeat (6) send_event(EV_RETRACE, 1'b0, 1'b0);
      wait_results_drained();
      write_frame_interval(8'd3);
      repeat (12) send_event(EV_RETRACE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      wait_results_drained();
      write_frame_interval(8'd255);
      repeat (262) send_event(EV_RETRACE, 1'b0, 1'b0);
   endtask

   // long receiver hold with a steady sender so the input side stalls
   task automatic test_backpressure_fill();
      wait_results_drained();
      sender_gaps = 1'b0;
      hold_off_req = 1'b1;
      repeat (24) send_event(3'($urandom_range(0, 4)), 1'($urandom_range(0, 1)), 1'b0);
      sender_gaps = 1'b1;
   endtask

   // weighted random events, mostly valid kinds so every state stays reachable
   task automatic test_random_traffic(input int count, input logic [INTERVAL_W-1:0] interval);
      int pick;
      logic [2:0] kind;
      wait_results_drained();
      write_frame_interval(interval);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) kind = EV_TASK_DONE;
         else if (pick < 52) kind = EV_RETRACE;
         else if (pick < 70) kind = EV_AUDIO_READY;
         else if (pick < 90) kind = EV_GFX_READY;
         else if (pick < 95) kind = EV_DISPLAY_DONE;
         else if (pick < 97) kind = EV_RSVD_5;
         else if (pick < 99) kind = EV_RSVD_6;
         else kind = EV_RSVD_7;
         send_event(kind, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
      end
   endtask

   // result ready with random stalls and one long requested hold
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result 0x%0h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            check_field("start_cmd", int'(got.start_cmd), int'(want.start_cmd));
            check_field("yield_request", int'(got.yield_request), int'(want.yield_request));
            check_field("flush_request", int'(got.flush_request), int'(want.flush_request));
            check_field("audio_tick", int'(got.audio_tick), int'(want.audio_tick));
            check_field("frame_tick", int'(got.frame_tick), int'(want.frame_tick));
            check_field("display_done", int'(got.display_done), int'(want.display_done));
            check_field("unit_busy", int'(got.unit_busy), int'(want.unit_busy));
            check_field("task_state_out", int'(got.task_state_out),
                        int'(want.task_state_out));
            check_field("padding", int'(rsp_tdata[RSP_DATA_W-1:$bits(result_type)]), 0);
         end
         result_index++;
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // test sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_events();
      test_frame_interval();
      test_backpressure_fill();
      test_random_traffic(350, INTERVAL_W'($urandom_range(1, 6)));
      test_random_traffic(350, 8'd0);
      test_random_traffic(350, INTERVAL_W'($urandom_range(2, 10)));
      wait_results_drained();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      test_random_traffic(350, INTERVAL_W'($urandom_range(1, 255)));
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
